// File: design/pcag_pkg.sv
// Package: shared types, codes and tone/shift-register helpers for the sound generator.
package pcag_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned TickCntW = $clog2(TickW);
  localparam int unsigned DivW    = 5;
  localparam int unsigned DsrW    = DivW + 1;
  localparam int unsigned VolW    = 4;
  localparam int unsigned ToneW   = 8;
  localparam int unsigned SampleW = 7;

  localparam logic [ToneW-1:0] ToneLast = 8'd185;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE0 = 3'd0,
    REG_MODE1 = 3'd1,
    REG_DIV0  = 3'd2,
    REG_DIV1  = 3'd3,
    REG_VOL0  = 3'd4,
    REG_VOL1  = 3'd5
  } reg_sel_e;

  typedef enum logic [3:0] {
    MODE_ONE_A     = 4'h0,
    MODE_P4        = 4'h1,
    MODE_T31_P4    = 4'h2,
    MODE_P5_P4     = 4'h3,
    MODE_T2_A      = 4'h4,
    MODE_T2_B      = 4'h5,
    MODE_T31_A     = 4'h6,
    MODE_P5_A      = 4'h7,
    MODE_P9        = 4'h8,
    MODE_P5_B      = 4'h9,
    MODE_T31_B     = 4'hA,
    MODE_ONE_B     = 4'hB,
    MODE_T6_A      = 4'hC,
    MODE_T6_B      = 4'hD,
    MODE_T93       = 4'hE,
    MODE_P5_T6     = 4'hF
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_RUN0,
    ST_LOAD1,
    ST_RUN1,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic mode;
    logic div;
    logic vol;
  } voice_wr_t;

  typedef struct packed {
    logic start;
  } rem_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_stat_t;

  function automatic logic [3:0] step_four(input logic [3:0] s);
    step_four = {s[0] ^ s[1], s[3:1]};
  endfunction

  function automatic logic [4:0] step_five(input logic [4:0] s);
    step_five = {s[0] ^ s[2], s[4:1]};
  endfunction

  function automatic logic [8:0] step_nine(input logic [8:0] s);
    step_nine = {s[0] ^ s[4], s[8:1]};
  endfunction

  function automatic logic [ToneW-1:0] bump_tone(input logic [ToneW-1:0] t);
    bump_tone = (t == ToneLast) ? '0 : t + 8'd1;
  endfunction

  // 32 = 1 mod 31, so fold the high bits onto the low five.
  function automatic logic [4:0] tone_mod31(input logic [ToneW-1:0] t);
    logic [5:0] s;
    s = {3'b000, t[7:5]} + {1'b0, t[4:0]};
    if (s >= 6'd31) begin
      s = s - 6'd31;
    end
    tone_mod31 = s[4:0];
  endfunction

  // Quotient by 6 via 171/1024, exact for tone values below 186.
  function automatic logic tone_mod6_low(input logic [ToneW-1:0] t);
    logic [15:0] p;
    logic [7:0]  q6;
    logic [7:0]  r;
    p  = {8'b0, t} * 16'd171;
    q6 = {2'b00, p[15:10]} * 8'd6;
    r  = t - q6;
    tone_mod6_low = (r < 8'd3);
  endfunction

  function automatic logic tone_mod93_low(input logic [ToneW-1:0] t);
    tone_mod93_low = (t < 8'd49) || ((t >= 8'd93) && (t < 8'd142));
  endfunction

endpackage

// File: design/pcag_rem_unit.sv
// Bit-serial restoring remainder unit: tick count modulo (divider + 1).
module pcag_rem_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcag_pkg::rem_ctrl_t           ctrl_i,
  input  logic [pcag_pkg::TickW-1:0]    dividend_i,
  input  logic [pcag_pkg::DsrW-1:0]     divisor_i,
  output pcag_pkg::rem_stat_t           stat_o
);

  logic [pcag_pkg::TickW-1:0]    dvd_q, dvd_d;
  logic [pcag_pkg::DsrW-1:0]     dsr_q, dsr_d;
  logic [pcag_pkg::DsrW-1:0]     rem_q, rem_d;
  logic [pcag_pkg::TickCntW-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [pcag_pkg::DsrW:0]       trial;

  assign trial = {rem_q, dvd_q[pcag_pkg::TickW-1]};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = pcag_pkg::TickCntW'(pcag_pkg::TickW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = pcag_pkg::DsrW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[pcag_pkg::DsrW-1:0];
      end
      dvd_d = {dvd_q[pcag_pkg::TickW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

endmodule

// File: design/pcag_voice.sv
// One channel: its registers, shift registers, tone counter and output bit.
module pcag_voice (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcag_pkg::voice_wr_t          wr_i,
  input  logic [7:0]                   wr_data_i,
  input  logic                         advance_i,
  output logic                         bit_o,
  output logic [pcag_pkg::VolW-1:0]    vol_o,
  output logic [pcag_pkg::DivW-1:0]    div_o
);

  pcag_pkg::mode_e             mode_q, mode_d;
  logic [pcag_pkg::DivW-1:0]   div_q, div_d;
  logic [pcag_pkg::VolW-1:0]   vol_q, vol_d;
  logic [3:0]                  four_q, four_d;
  logic [4:0]                  five_q, five_d;
  logic [8:0]                  nine_q, nine_d;
  logic [pcag_pkg::ToneW-1:0]  tone_q, tone_d;
  logic [4:0]                  five_nx;
  logic [pcag_pkg::ToneW-1:0]  tone_nx;
  logic [4:0]                  tone_nx_m31;

  assign five_nx     = pcag_pkg::step_five(five_q);
  assign tone_nx     = pcag_pkg::bump_tone(tone_q);
  assign tone_nx_m31 = pcag_pkg::tone_mod31(tone_nx);

  always_comb begin
    unique case (mode_q)
      pcag_pkg::MODE_ONE_A, pcag_pkg::MODE_ONE_B: bit_o = 1'b1;
      pcag_pkg::MODE_P4, pcag_pkg::MODE_T31_P4,
      pcag_pkg::MODE_P5_P4:                       bit_o = four_q[0];
      pcag_pkg::MODE_T2_A, pcag_pkg::MODE_T2_B:   bit_o = tone_q[0];
      pcag_pkg::MODE_T31_A, pcag_pkg::MODE_T31_B:
        bit_o = (pcag_pkg::tone_mod31(tone_q) < 5'd18);
      pcag_pkg::MODE_P5_A, pcag_pkg::MODE_P5_B:   bit_o = five_q[0];
      pcag_pkg::MODE_P9:                          bit_o = nine_q[0];
      pcag_pkg::MODE_T93:                         bit_o = pcag_pkg::tone_mod93_low(tone_q);
      default:                                    bit_o = pcag_pkg::tone_mod6_low(tone_q);
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    div_d  = div_q;
    vol_d  = vol_q;
    four_d = four_q;
    five_d = five_q;
    nine_d = nine_q;
    tone_d = tone_q;
    if (wr_i.mode) begin
      mode_d = pcag_pkg::mode_e'(wr_data_i[3:0]);
    end
    if (wr_i.div) begin
      div_d = wr_data_i[pcag_pkg::DivW-1:0];
    end
    if (wr_i.vol) begin
      vol_d = wr_data_i[pcag_pkg::VolW-1:0];
    end
    if (advance_i) begin
      unique case (mode_q)
        pcag_pkg::MODE_P4: four_d = pcag_pkg::step_four(four_q);
        pcag_pkg::MODE_T31_P4: begin
          tone_d = tone_nx;
          if (tone_nx_m31 == 5'd0 || tone_nx_m31 == 5'd18) begin
            four_d = pcag_pkg::step_four(four_q);
          end
        end
        pcag_pkg::MODE_P5_P4: begin
          five_d = five_nx;
          if (five_nx[0]) begin
            four_d = pcag_pkg::step_four(four_q);
          end
        end
        pcag_pkg::MODE_T2_A, pcag_pkg::MODE_T2_B, pcag_pkg::MODE_T31_A,
        pcag_pkg::MODE_T31_B, pcag_pkg::MODE_T6_A, pcag_pkg::MODE_T6_B,
        pcag_pkg::MODE_T93: tone_d = tone_nx;
        pcag_pkg::MODE_P5_A, pcag_pkg::MODE_P5_B: five_d = five_nx;
        pcag_pkg::MODE_P9: nine_d = pcag_pkg::step_nine(nine_q);
        pcag_pkg::MODE_P5_T6: begin
          five_d = five_nx;
          // bump the tone counter only on an edge of the shift register output
          if (five_nx[0] != five_q[0]) begin
            tone_d = tone_nx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pcag_pkg::MODE_ONE_A;
      div_q  <= '0;
      vol_q  <= '0;
      four_q <= 4'hF;
      five_q <= 5'h1F;
      nine_q <= 9'h1FF;
      tone_q <= '0;
    end else begin
      mode_q <= mode_d;
      div_q  <= div_d;
      vol_q  <= vol_d;
      four_q <= four_d;
      five_q <= five_d;
      nine_q <= nine_d;
      tone_q <= tone_d;
    end
  end

  assign vol_o = vol_q;
  assign div_o = div_q;

endmodule

// File: design/poly_counter_audio_generator_top.sv
// Top level: handshake, register decode, tick sequencer and output register.
// Register writes and ticks are accepted only while the sequencer is idle, so no new tick or
// write is taken until the last tick's sample has been emitted. Per channel: a load step and
// a run of the shared bit-serial remainder unit (tick count modulo divider+1); then the
// emit step, which output stalls extend, registers the sample. Reset (rst_ni low, asynchronous)
// clears the channel registers and tick count and presets the shift registers to all ones.
module poly_counter_audio_generator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [2:0]                      reg_select_i,
  input  logic [7:0]                      write_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pcag_pkg::SampleW-1:0]    sample_o
);

  pcag_pkg::seq_state_e             state_q, state_d;
  logic [pcag_pkg::TickW-1:0]       tick_q, tick_d;
  logic [pcag_pkg::SampleW-1:0]     pend_q, pend_d;
  logic [pcag_pkg::SampleW-1:0]     sample_q, sample_d;
  logic                             out_valid_q, out_valid_d;

  logic                             in_fire;
  logic                             tick_fire;
  logic                             wr_fire;
  logic                             emit_fire;
  pcag_pkg::voice_wr_t              wr0, wr1;
  logic                             adv0, adv1;
  logic                             bit0, bit1;
  logic [pcag_pkg::VolW-1:0]        vol0, vol1;
  logic [pcag_pkg::DivW-1:0]        div0, div1;
  logic [pcag_pkg::VolW-1:0]        lvl0, lvl1, lvl_max;
  logic [pcag_pkg::DsrW-1:0]        divisor;
  pcag_pkg::rem_ctrl_t              rem_ctrl;
  pcag_pkg::rem_stat_t              rem_stat;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign tick_fire = in_fire && (func_i == pcag_pkg::FUNC_TICK);
  assign wr_fire   = in_fire && (func_i == pcag_pkg::FUNC_WRITE);

  // register write decode
  always_comb begin
    wr0 = '0;
    wr1 = '0;
    if (wr_fire) begin
      unique case (reg_select_i)
        pcag_pkg::REG_MODE0: wr0.mode = 1'b1;
        pcag_pkg::REG_MODE1: wr1.mode = 1'b1;
        pcag_pkg::REG_DIV0:  wr0.div  = 1'b1;
        pcag_pkg::REG_DIV1:  wr1.div  = 1'b1;
        pcag_pkg::REG_VOL0:  wr0.vol  = 1'b1;
        pcag_pkg::REG_VOL1:  wr1.vol  = 1'b1;
        default: ;
      endcase
    end
  end

  pcag_voice u_voice0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr0),
    .wr_data_i (write_data_i),
    .advance_i (adv0),
    .bit_o     (bit0),
    .vol_o     (vol0),
    .div_o     (div0)
  );

  pcag_voice u_voice1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr1),
    .wr_data_i (write_data_i),
    .advance_i (adv1),
    .bit_o     (bit1),
    .vol_o     (vol1),
    .div_o     (div1)
  );

  pcag_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rem_ctrl),
    .dividend_i (tick_q),
    .divisor_i  (divisor),
    .stat_o     (rem_stat)
  );

  assign lvl0    = bit0 ? vol0 : '0;
  assign lvl1    = bit1 ? vol1 : '0;
  assign lvl_max = (lvl0 > lvl1) ? lvl0 : lvl1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcag_pkg::ST_IDLE:  if (tick_fire) state_d = pcag_pkg::ST_LOAD0;
      pcag_pkg::ST_LOAD0: state_d = pcag_pkg::ST_RUN0;
      pcag_pkg::ST_RUN0:  if (rem_stat.done) state_d = pcag_pkg::ST_LOAD1;
      pcag_pkg::ST_LOAD1: state_d = pcag_pkg::ST_RUN1;
      pcag_pkg::ST_RUN1:  if (rem_stat.done) state_d = pcag_pkg::ST_EMIT;
      pcag_pkg::ST_EMIT:  if (emit_fire) state_d = pcag_pkg::ST_IDLE;
      default:            state_d = pcag_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o     = 1'b1;
    rem_ctrl.start = 1'b0;
    divisor        = {1'b0, div0} + 1'b1;
    adv0           = 1'b0;
    adv1           = 1'b0;
    emit_fire      = 1'b0;
    unique case (state_q)
      pcag_pkg::ST_IDLE:  in_stall_o = 1'b0;
      pcag_pkg::ST_LOAD0: rem_ctrl.start = 1'b1;
      pcag_pkg::ST_RUN0:  adv0 = rem_stat.done && rem_stat.zero;
      pcag_pkg::ST_LOAD1: begin
        rem_ctrl.start = 1'b1;
        divisor        = {1'b0, div1} + 1'b1;
      end
      pcag_pkg::ST_RUN1:  adv1 = rem_stat.done && rem_stat.zero;
      pcag_pkg::ST_EMIT:  emit_fire = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_comb begin
    tick_d      = tick_q;
    pend_d      = pend_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (tick_fire) begin
      // capture the sample before the channels step
      tick_d = tick_q + 1'b1;
      pend_d = {lvl_max, 3'b000};
    end
    if (emit_fire) begin
      sample_d    = pend_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcag_pkg::ST_IDLE;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    sample_q <= sample_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

`ifndef SYNTH
  a_tick_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> (state_q == pcag_pkg::ST_LOAD0))
    else $error("accepted tick did not start the sequencer");

  a_tick_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> (tick_q == $past(tick_q) + 1'b1))
    else $error("tick count did not advance by one");

  a_rem_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_stat.done |-> (state_q == pcag_pkg::ST_RUN0 || state_q == pcag_pkg::ST_RUN1))
    else $error("remainder finished outside a run state");

  a_rem_idle_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcag_pkg::ST_IDLE) |-> !rem_stat.busy)
    else $error("remainder unit busy while the sequencer is idle");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pcag_pkg::ST_EMIT))
    else $error("output beat not produced by the emit step");

  a_single_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv0 && adv1))
    else $error("both channels advanced in one cycle");
`endif

endmodule
